[rtl/core/bsh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bsh_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_DEBOUNCE  = 3'd0,
    CFG_STEP_WAIT = 3'd1,
    CFG_HEARTBEAT = 3'd2,
    CFG_NUDGE     = 3'd3,
    CFG_SWEEP     = 3'd4,
    CFG_STARTUP   = 3'd5
  } cfg_idx_t;

  localparam logic [7:0]  DEBOUNCE_RST  = 8'd10;
  localparam logic [15:0] STEP_WAIT_RST = 16'd15;
  localparam logic [15:0] HEARTBEAT_RST = 16'd500;
  localparam logic [7:0]  NUDGE_RST     = 8'd2;
  localparam logic [7:0]  SWEEP_RST     = 8'd200;
  localparam logic [7:0]  STARTUP_RST   = 8'd8;

  localparam logic [5:0]  PATTERN_OFF   = 6'h39;
  localparam logic [7:0]  HOLD_MAX      = 8'd255;
  localparam int          NUM_BUTTONS   = 4;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] step_wait_ticks;
    logic [15:0] heartbeat_ticks;
    logic [7:0]  nudge_steps;
    logic [7:0]  sweep_steps;
    logic [7:0]  startup_steps;
  } cfg_t;

  // One classified tick: presses registered in it and the heartbeat level
  typedef struct packed {
    logic [NUM_BUTTONS-1:0] press;
    logic                   heartbeat;
  } tick_rec_t;

  typedef struct packed {
    logic [5:0] phase_pattern;
    logic       heartbeat_led;
    logic       toggle_led;
    logic       motor_busy;
  } result_t;

  typedef struct packed {
    logic       active;
    logic [5:0] drive;
  } motor_status_t;

  // Half-step phase table
  function automatic logic [5:0] phase_lut(input logic [2:0] idx);
    logic [5:0] pat;
    case (idx)
      3'd0:    pat = 6'h3C;
      3'd1:    pat = 6'h2E;
      3'd2:    pat = 6'h2B;
      3'd3:    pat = 6'h27;
      3'd4:    pat = 6'h35;
      3'd5:    pat = 6'h17;
      3'd6:    pat = 6'h1B;
      3'd7:    pat = 6'h1E;
      default: pat = PATTERN_OFF;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

[rtl/core/bsh_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsh_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Advance pointers with wrap and track occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store request payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bsh_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsh_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              accept,
  input  wire logic [bsh_pkg::NUM_BUTTONS-1:0]   buttons,
  input  wire bsh_pkg::cfg_t                     cfg,
  output bsh_pkg::tick_rec_t                     rec
);

  localparam int NB = bsh_pkg::NUM_BUTTONS;

  logic [15:0] tick_r, tick_nxt, tick_inc;
  logic        hb_r, hb_nxt;
  logic [7:0]  hold_r [NB];
  logic [7:0]  hold_nxt [NB];
  logic [NB-1:0] rel_r, rel_nxt;
  logic [NB-1:0] press;

  // Divide ticks for the heartbeat
  always_comb begin
    tick_inc = tick_r + 16'd1;
    tick_nxt = tick_inc;
    hb_nxt   = hb_r;
    if (tick_inc >= cfg.heartbeat_ticks) begin
      tick_nxt = '0;
      hb_nxt   = ~hb_r;
    end
  end

  // Debounce each button: one press per hold, only after a release
  always_comb begin
    for (int i = 0; i < NB; i++) begin
      press[i]    = 1'b0;
      rel_nxt[i]  = rel_r[i];
      hold_nxt[i] = hold_r[i];
      if (buttons[i]) begin
        if (hold_r[i] != bsh_pkg::HOLD_MAX) begin
          hold_nxt[i] = hold_r[i] + 8'd1;
        end
        if ((hold_nxt[i] >= cfg.debounce_ticks) && rel_r[i]) begin
          press[i]   = 1'b1;
          rel_nxt[i] = 1'b0;
        end
      end else begin
        hold_nxt[i] = '0;
        rel_nxt[i]  = 1'b1;
      end
    end
  end

  assign rec.press     = press;
  assign rec.heartbeat = hb_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      hb_r   <= 1'b0;
      rel_r  <= '0;
      for (int i = 0; i < NB; i++) begin
        hold_r[i] <= '0;
      end
    end else if (accept) begin
      tick_r <= tick_nxt;
      hb_r   <= hb_nxt;
      rel_r  <= rel_nxt;
      for (int i = 0; i < NB; i++) begin
        hold_r[i] <= hold_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/bsh_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsh_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire bsh_pkg::cfg_t         cfg,
  input  wire logic                  startup_wr,
  input  wire logic [7:0]            startup_val,
  input  wire logic                  rec_valid,
  input  wire bsh_pkg::tick_rec_t    rec,
  output logic                       rec_take,
  input  wire logic                  res_full,
  output bsh_pkg::result_t           res,
  output bsh_pkg::motor_status_t     status
);

  localparam int NB = bsh_pkg::NUM_BUTTONS;

  logic [NB-1:0] pend_r, pend_nxt;
  logic          tog_r, tog_nxt;
  logic          act_r, act_nxt;
  logic [7:0]    steps_r, steps_nxt;
  logic          mdir_r, mdir_nxt;
  logic          sdir_r, sdir_nxt;
  logic [15:0]   wait_r, wait_nxt;
  logic [2:0]    ph_r, ph_nxt;
  logic [5:0]    drv_r, drv_nxt;
  logic          armed_r;

  assign rec_take = rec_valid && !res_full;

  // Dispatch pending presses while idle, then run one motor tick
  always_comb begin
    pend_nxt  = pend_r | rec.press;
    tog_nxt   = tog_r;
    act_nxt   = act_r;
    steps_nxt = steps_r;
    mdir_nxt  = mdir_r;
    sdir_nxt  = sdir_r;
    wait_nxt  = wait_r;
    ph_nxt    = ph_r;
    drv_nxt   = drv_r;
    if (!act_r) begin
      if (pend_nxt[0]) begin
        pend_nxt[0] = 1'b0;
        tog_nxt     = ~tog_r;
      end
      if (pend_nxt[1]) begin
        pend_nxt[1] = 1'b0;
        steps_nxt   = cfg.nudge_steps;
        mdir_nxt    = 1'b1;
        wait_nxt    = '0;
        act_nxt     = 1'b1;
      end else if (pend_nxt[2]) begin
        pend_nxt[2] = 1'b0;
        steps_nxt   = cfg.nudge_steps;
        mdir_nxt    = 1'b0;
        wait_nxt    = '0;
        act_nxt     = 1'b1;
      end else if (pend_nxt[3]) begin
        pend_nxt[3] = 1'b0;
        steps_nxt   = cfg.sweep_steps;
        mdir_nxt    = sdir_r;
        sdir_nxt    = ~sdir_r;
        wait_nxt    = '0;
        act_nxt     = 1'b1;
      end
    end
    if (act_nxt) begin
      if (wait_nxt > 16'd1) begin
        wait_nxt = wait_nxt - 16'd1;
      end else if (steps_nxt != '0) begin
        ph_nxt    = mdir_nxt ? (ph_r - 3'd1) : (ph_r + 3'd1);
        drv_nxt   = bsh_pkg::phase_lut(ph_nxt);
        steps_nxt = steps_nxt - 8'd1;
        wait_nxt  = cfg.step_wait_ticks;
      end else begin
        drv_nxt  = bsh_pkg::PATTERN_OFF;
        act_nxt  = 1'b0;
        wait_nxt = '0;
      end
    end
  end

  assign res.phase_pattern = drv_nxt;
  assign res.heartbeat_led = rec.heartbeat;
  assign res.toggle_led    = tog_nxt;
  assign res.motor_busy    = act_nxt;

  assign status.active = act_r;
  assign status.drive  = drv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      tog_r   <= 1'b0;
      act_r   <= 1'b1;
      steps_r <= bsh_pkg::STARTUP_RST;
      mdir_r  <= 1'b0;
      sdir_r  <= 1'b0;
      wait_r  <= '0;
      ph_r    <= '0;
      drv_r   <= bsh_pkg::PATTERN_OFF;
      armed_r <= 1'b1;
    end else if (rec_take) begin
      pend_r  <= pend_nxt;
      tog_r   <= tog_nxt;
      act_r   <= act_nxt;
      steps_r <= steps_nxt;
      mdir_r  <= mdir_nxt;
      sdir_r  <= sdir_nxt;
      wait_r  <= wait_nxt;
      ph_r    <= ph_nxt;
      drv_r   <= drv_nxt;
      armed_r <= 1'b0;
    end else if (startup_wr && armed_r) begin
      // Reload the startup move until the first tick
      steps_r <= startup_val;
    end
  end

endmodule

`default_nettype wire

[rtl/core/button_stepper_half_step_controller.sv]
// Button-driven half-step stepper controller.
// Input channel (push/full): one request per 1 ms tick with four raw button
// levels; accepted at a clock edge with push high and full low.
// Result channel (empty/pop): one result per tick, oldest first, holding the
// phase pattern, heartbeat LED, toggle LED and busy flag after that tick.
// Configuration: cfg_wr_en, cfg_index and cfg_wdata write one register per
// edge; write only while no tick is in flight.
// A front stage debounces buttons and divides the heartbeat, a queue carries
// its classified ticks to a back stage that dispatches presses and walks
// the half-step table into a result queue.
// A tick is held in the tick queue, then its result in the result queue.
// Throughput: one tick per cycle while the result queue is not full.
// When pop is held low the result queue fills, then the tick queue, and
// full rises; nothing is lost and accepting resumes as results drain.
// Reset (rst_n low at an edge) restores register defaults, empties both
// queues and arms the clockwise startup move; writing startup_steps before
// the first tick also sets that move's length.
`timescale 1ns / 1ps
`default_nettype none

module button_stepper_half_step_controller #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic        in_button_zero,
  input  wire logic        in_button_one,
  input  wire logic        in_button_two,
  input  wire logic        in_button_three,
  output logic             empty,
  input  wire logic        pop,
  output logic [5:0]       out_phase_pattern,
  output logic             out_heartbeat_led,
  output logic             out_toggle_led,
  output logic             out_motor_busy,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int REC_W = $bits(bsh_pkg::tick_rec_t);
  localparam int RES_W = $bits(bsh_pkg::result_t);

  bsh_pkg::cfg_t          cfg_r;
  bsh_pkg::tick_rec_t     front_rec, back_rec;
  bsh_pkg::result_t       back_res, out_res;
  bsh_pkg::motor_status_t status;
  logic                   accept;
  logic                   mid_empty, rec_take, res_full;
  logic                   startup_wr;

  assign accept     = push && !full;
  assign startup_wr = cfg_wr_en && (cfg_index == bsh_pkg::CFG_STARTUP);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks  <= bsh_pkg::DEBOUNCE_RST;
      cfg_r.step_wait_ticks <= bsh_pkg::STEP_WAIT_RST;
      cfg_r.heartbeat_ticks <= bsh_pkg::HEARTBEAT_RST;
      cfg_r.nudge_steps     <= bsh_pkg::NUDGE_RST;
      cfg_r.sweep_steps     <= bsh_pkg::SWEEP_RST;
      cfg_r.startup_steps   <= bsh_pkg::STARTUP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bsh_pkg::CFG_DEBOUNCE:  cfg_r.debounce_ticks  <= cfg_wdata[7:0];
        bsh_pkg::CFG_STEP_WAIT: cfg_r.step_wait_ticks <= cfg_wdata;
        bsh_pkg::CFG_HEARTBEAT: cfg_r.heartbeat_ticks <= cfg_wdata;
        bsh_pkg::CFG_NUDGE:     cfg_r.nudge_steps     <= cfg_wdata[7:0];
        bsh_pkg::CFG_SWEEP:     cfg_r.sweep_steps     <= cfg_wdata[7:0];
        bsh_pkg::CFG_STARTUP:   cfg_r.startup_steps   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  bsh_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .buttons ({in_button_three, in_button_two, in_button_one, in_button_zero}),
    .cfg     (cfg_r),
    .rec     (front_rec)
  );

  bsh_fifo #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_tick_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (front_rec),
    .full  (full),
    .pop   (rec_take),
    .rdata (back_rec),
    .empty (mid_empty)
  );

  bsh_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .startup_wr  (startup_wr),
    .startup_val (cfg_wdata[7:0]),
    .rec_valid   (!mid_empty),
    .rec         (back_rec),
    .rec_take    (rec_take),
    .res_full    (res_full),
    .res         (back_res),
    .status      (status)
  );

  bsh_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rec_take),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_res),
    .empty (empty)
  );

  assign out_phase_pattern = out_res.phase_pattern;
  assign out_heartbeat_led = out_res.heartbeat_led;
  assign out_toggle_led    = out_res.toggle_led;
  assign out_motor_busy    = out_res.motor_busy;

  // Windings are off whenever the motor is idle
  a_idle_off: assert property (@(posedge clk) disable iff (!rst_n)
    !status.active |-> (status.drive == bsh_pkg::PATTERN_OFF))
    else $error("idle motor with energized windings");

  // An accepted tick lands in the tick queue
  a_tick_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !rec_take) |=> !mid_empty)
    else $error("accepted tick missing from queue");

  // A taken tick always produces a queued result
  a_result_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (rec_take && !pop) |=> !empty)
    else $error("taken tick produced no result");

endmodule

`default_nettype wire
